FILE: rtl/core/hav_pkg.sv
package hav_pkg;

  localparam int ITERS     = 30;
  localparam int UNITS     = 4;
  localparam int SQ_STG    = 31;
  localparam int CONV_STG  = 6;
  localparam int MUL_STG   = 4;
  localparam int FIN_STG   = 5;
  localparam int LAT       = CONV_STG + ITERS + 1 + MUL_STG + SQ_STG + ITERS + FIN_STG;
  localparam int HAV_STG   = CONV_STG + ITERS + 1 + MUL_STG;
  localparam int SQ_END    = HAV_STG + SQ_STG;
  localparam int VEC_END   = SQ_END + ITERS;
  localparam int CLAMP_STG = VEC_END + 1;

  localparam logic [31:0]        TURN      = 32'd3600000000;
  localparam logic [31:0]        HALF_TURN = 32'd1800000000;
  localparam logic [34:0]        TWO_TURN  = 35'd7200000000;
  localparam logic signed [33:0] TURN_S    = 34'sd3600000000;
  localparam logic signed [33:0] TURN2_S   = 34'sd7200000000;
  localparam logic [31:0]        K31       = 32'd2562047788;
  localparam logic [31:0]        K32_LO    = 32'd829128280;

  localparam logic signed [31:0] GAIN      = 32'sd652032874;
  localparam logic signed [63:0] RND_Q30   = 64'sd536870912;
  localparam logic [60:0]        ONE_Q60   = {1'b1, 60'd0};
  localparam logic [30:0]        ONE_Q30   = {1'b1, 30'd0};
  localparam logic signed [32:0] ONE_Q30_S = 33'sd1073741824;

  localparam logic [9:0]  PI_HI      = 10'd804;
  localparam logic [31:0] PI_LO      = 32'd1063946374;
  localparam logic [22:0] RADIUS_RST = 23'd6371000;
  localparam logic [9:0]  MM_PER_M   = 10'd1000;

  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;

  typedef logic signed [31:0] q30_t;

  function automatic logic [29:0] atan_turns(input int i);
    logic [29:0] v;
    case (i)
      0:  v = 30'h20000000;
      1:  v = 30'h12E4051E;
      2:  v = 30'h09FB385B;
      3:  v = 30'h051111D4;
      4:  v = 30'h028B0D43;
      5:  v = 30'h0145D7E1;
      6:  v = 30'h00A2F61E;
      7:  v = 30'h00517C55;
      8:  v = 30'h0028BE53;
      9:  v = 30'h00145F2F;
      10: v = 30'h000A2F98;
      11: v = 30'h000517CC;
      12: v = 30'h00028BE6;
      13: v = 30'h000145F3;
      14: v = 30'h0000A2FA;
      15: v = 30'h0000517D;
      16: v = 30'h000028BE;
      17: v = 30'h0000145F;
      18: v = 30'h00000A30;
      19: v = 30'h00000518;
      20: v = 30'h0000028C;
      21: v = 30'h00000146;
      22: v = 30'h000000A3;
      23: v = 30'h00000051;
      24: v = 30'h00000029;
      25: v = 30'h00000014;
      26: v = 30'h0000000A;
      27: v = 30'h00000005;
      28: v = 30'h00000003;
      29: v = 30'h00000001;
      default: v = 30'h0;
    endcase
    return v;
  endfunction

endpackage

FILE: rtl/core/haversine_distance.sv
// Great-circle distance in millimetres between two points given in 1e-7 degree,
// by the haversine formula on a sphere whose radius (metres) is cfg_wdata.
// Fully pipelined: a word is taken on every cycle that start is high, and busy is
// always low. Each result is on out_distance_mm with out_valid for one cycle. The
// receiver cannot hold results off. The latency is set by the two 30-stage CORDIC
// chains, the 31-stage square-root pipeline and the angle-conversion and
// multiply stages around them. Write the radius only while no word is in flight.
module haversine_distance
  import hav_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [30:0] in_lat_a,
  input  logic signed [31:0] in_lon_a,
  input  logic signed [30:0] in_lat_b,
  input  logic signed [31:0] in_lon_b,
  output logic               out_valid,
  output logic [34:0]        out_distance_mm,
  input  logic               cfg_we,
  input  logic [22:0]        cfg_wdata
);

  logic [22:0]    radius_r, radius_nxt;
  logic [LAT-1:0] vld_r, vld_nxt;

  assign busy = 1'b0;

  always_comb begin
    radius_nxt = cfg_we ? cfg_wdata : radius_r;
    vld_nxt    = {vld_r[LAT-2:0], start & ~busy};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= RADIUS_RST;
      vld_r    <= '0;
    end else begin
      radius_r <= radius_nxt;
      vld_r    <= vld_nxt;
    end
  end

  logic signed [33:0] d_r [UNITS];
  logic [31:0]        u_r [UNITS];
  logic [31:0]        u3_r [UNITS];
  logic [63:0]        prod_r [UNITS];
  logic [32:0]        qe_r [UNITS];
  logic [32:0]        qe5_r [UNITS];
  logic [34:0]        nlo_r [UNITS];
  logic [34:0]        nlo5_r [UNITS];
  logic [34:0]        m_r [UNITS];

  logic signed [33:0] md_p1 [UNITS];
  logic signed [33:0] md_p2 [UNITS];
  logic signed [33:0] md_m1 [UNITS];
  logic [31:0]        u_nxt [UNITS];
  logic [32:0]        qe_nxt [UNITS];
  logic [34:0]        nlo_nxt [UNITS];
  logic [64:0]        m_full [UNITS];
  logic [34:0]        rem [UNITS];
  logic [32:0]        qf [UNITS];

  q30_t               rx_r [1:ITERS][UNITS];
  q30_t               ry_r [1:ITERS][UNITS];
  logic signed [31:0] rz_r [0:ITERS][UNITS];
  logic [1:0]         rq_r [0:ITERS][UNITS];

  always_ff @(posedge clk) begin
    d_r[0] <= 34'(in_lat_b) - 34'(in_lat_a);
    d_r[1] <= 34'(in_lon_b) - 34'(in_lon_a);
    d_r[2] <= 34'(in_lat_a);
    d_r[3] <= 34'(in_lat_b);
  end

  always_comb begin
    for (int k = 0; k < UNITS; k++) begin
      md_p1[k] = d_r[k] + TURN_S;
      md_p2[k] = d_r[k] + TURN2_S;
      md_m1[k] = d_r[k] - TURN_S;
      if (d_r[k] < 0) begin
        u_nxt[k] = (md_p1[k] < 0) ? md_p2[k][31:0] : md_p1[k][31:0];
      end else begin
        u_nxt[k] = (md_m1[k] >= 0) ? md_m1[k][31:0] : d_r[k][31:0];
      end
      if (k < 2) begin
        qe_nxt[k]  = {1'b0, prod_r[k][63:32]};
        nlo_nxt[k] = {u3_r[k][3:0], 31'd0} + 35'(HALF_TURN);
      end else begin
        qe_nxt[k]  = 33'(u3_r[k]) + 33'(prod_r[k][63:32]);
        nlo_nxt[k] = {u3_r[k][2:0], 32'd0} + 35'(HALF_TURN);
      end
      m_full[k] = 65'(qe_r[k]) * 65'(TURN);
      rem[k]    = nlo5_r[k] - m_r[k];
      qf[k]     = qe5_r[k] + 33'(rem[k] >= 35'(TURN)) + 33'(rem[k] >= TWO_TURN);
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < UNITS; k++) begin
      u_r[k]    <= u_nxt[k];
      prod_r[k] <= 64'(u_r[k]) * 64'((k < 2) ? K31 : K32_LO);
      u3_r[k]   <= u_r[k];
      qe_r[k]   <= qe_nxt[k];
      nlo_r[k]  <= nlo_nxt[k];
      m_r[k]    <= m_full[k][34:0];
      qe5_r[k]  <= qe_r[k];
      nlo5_r[k] <= nlo_r[k];
      rz_r[0][k] <= $signed({2'b00, qf[k][29:0]});
      rq_r[0][k] <= qf[k][31:30];
    end
  end

  for (genvar i = 0; i < ITERS; i++) begin : g_rot
    q30_t xi [UNITS];
    q30_t yi [UNITS];
    if (i == 0) begin : g_first
      always_comb begin
        for (int k = 0; k < UNITS; k++) begin
          xi[k] = GAIN;
          yi[k] = '0;
        end
      end
    end else begin : g_next
      always_comb begin
        for (int k = 0; k < UNITS; k++) begin
          xi[k] = rx_r[i][k];
          yi[k] = ry_r[i][k];
        end
      end
    end
    always_ff @(posedge clk) begin
      for (int k = 0; k < UNITS; k++) begin
        if (!rz_r[i][k][31]) begin
          rx_r[i+1][k] <= xi[k] - (yi[k] >>> i);
          ry_r[i+1][k] <= yi[k] + (xi[k] >>> i);
          rz_r[i+1][k] <= rz_r[i][k] - $signed({2'b00, atan_turns(i)});
        end else begin
          rx_r[i+1][k] <= xi[k] + (yi[k] >>> i);
          ry_r[i+1][k] <= yi[k] - (xi[k] >>> i);
          rz_r[i+1][k] <= rz_r[i][k] + $signed({2'b00, atan_turns(i)});
        end
        rq_r[i+1][k] <= rq_r[i][k];
      end
    end
  end

  q30_t sin_r [UNITS];
  q30_t cos_r [UNITS];

  always_ff @(posedge clk) begin
    for (int k = 0; k < UNITS; k++) begin
      case (rq_r[ITERS][k])
        QUAD_0: begin
          cos_r[k] <= rx_r[ITERS][k];
          sin_r[k] <= ry_r[ITERS][k];
        end
        QUAD_1: begin
          cos_r[k] <= -ry_r[ITERS][k];
          sin_r[k] <= rx_r[ITERS][k];
        end
        QUAD_2: begin
          cos_r[k] <= -rx_r[ITERS][k];
          sin_r[k] <= -ry_r[ITERS][k];
        end
        default: begin
          cos_r[k] <= ry_r[ITERS][k];
          sin_r[k] <= -rx_r[ITERS][k];
        end
      endcase
    end
  end

  logic signed [32:0] cc_r, cc_nxt;
  logic signed [63:0] s1sq_r, s1sq2_r, s1sq3_r;
  q30_t               s2a_r, s2b_r;
  logic signed [32:0] t_r, t_nxt;
  logic signed [64:0] ts2_r;
  logic [60:0]        hav_r, hav_nxt, omh_r;
  logic signed [63:0] cab_full;
  logic signed [64:0] ct_full;
  logic signed [65:0] hsum;

  always_comb begin
    cab_full = cos_r[2] * cos_r[3];
    cc_nxt   = 33'((cab_full + RND_Q30) >>> 30);
    ct_full  = cc_r * s2a_r;
    t_nxt    = 33'((ct_full + 65'(RND_Q30)) >>> 30);
    hsum     = 66'(s1sq3_r) + 66'(ts2_r);
    if (hsum < 0) begin
      hav_nxt = '0;
    end else if (hsum > $signed({5'd0, ONE_Q60})) begin
      hav_nxt = ONE_Q60;
    end else begin
      hav_nxt = hsum[60:0];
    end
  end

  always_ff @(posedge clk) begin
    cc_r    <= cc_nxt;
    s1sq_r  <= sin_r[0] * sin_r[0];
    s2a_r   <= sin_r[1];
    t_r     <= t_nxt;
    s1sq2_r <= s1sq_r;
    s2b_r   <= s2a_r;
    ts2_r   <= t_r * s2b_r;
    s1sq3_r <= s1sq2_r;
    hav_r   <= hav_nxt;
    omh_r   <= ONE_Q60 - hav_nxt;
  end

  logic [60:0] sq_rem_r [1:SQ_STG][2];
  logic [61:0] sq_root_r [1:SQ_STG][2];

  for (genvar j = 0; j < SQ_STG; j++) begin : g_sqrt
    localparam logic [61:0] BIT = 62'd1 << (2 * (SQ_STG - 1 - j));
    logic [60:0] rin [2];
    logic [61:0] oin [2];
    logic [61:0] trial [2];
    if (j == 0) begin : g_first
      always_comb begin
        rin[0] = hav_r;
        rin[1] = omh_r;
        oin[0] = '0;
        oin[1] = '0;
      end
    end else begin : g_next
      always_comb begin
        for (int k = 0; k < 2; k++) begin
          rin[k] = sq_rem_r[j][k];
          oin[k] = sq_root_r[j][k];
        end
      end
    end
    always_comb begin
      for (int k = 0; k < 2; k++) begin
        trial[k] = oin[k] + BIT;
      end
    end
    always_ff @(posedge clk) begin
      for (int k = 0; k < 2; k++) begin
        if ({1'b0, rin[k]} >= trial[k]) begin
          sq_rem_r[j+1][k]  <= rin[k] - trial[k][60:0];
          sq_root_r[j+1][k] <= (oin[k] >> 1) + BIT;
        end else begin
          sq_rem_r[j+1][k]  <= rin[k];
          sq_root_r[j+1][k] <= oin[k] >> 1;
        end
      end
    end
  end

  logic signed [33:0] vx_r [1:ITERS];
  logic signed [33:0] vy_r [1:ITERS];
  logic signed [32:0] vz_r [1:ITERS];

  for (genvar i = 0; i < ITERS; i++) begin : g_vec
    logic signed [33:0] xi, yi;
    logic signed [32:0] zi;
    if (i == 0) begin : g_first
      always_comb begin
        xi = $signed({3'b000, sq_root_r[SQ_STG][1][30:0]});
        yi = $signed({3'b000, sq_root_r[SQ_STG][0][30:0]});
        zi = '0;
      end
    end else begin : g_next
      always_comb begin
        xi = vx_r[i];
        yi = vy_r[i];
        zi = vz_r[i];
      end
    end
    always_ff @(posedge clk) begin
      if (!yi[33]) begin
        vx_r[i+1] <= xi + (yi >>> i);
        vy_r[i+1] <= yi - (xi >>> i);
        vz_r[i+1] <= zi + $signed({3'b000, atan_turns(i)});
      end else begin
        vx_r[i+1] <= xi - (yi >>> i);
        vy_r[i+1] <= yi + (xi >>> i);
        vz_r[i+1] <= zi - $signed({3'b000, atan_turns(i)});
      end
    end
  end

  logic [30:0]  zc_r, zc_nxt;
  logic [32:0]  rk_r;
  logic [62:0]  qv_r;
  logic [63:0]  qv_full;
  logic [63:0]  pp00_r;
  logic [41:0]  pp01_r;
  logic [62:0]  pp10_r;
  logic [40:0]  pp11_r, pp11b_r;
  logic [65:0]  acc_r;
  logic [75:0]  fsum;
  logic [34:0]  dist_r;

  always_comb begin
    if (vz_r[ITERS] < 0) begin
      zc_nxt = '0;
    end else if (vz_r[ITERS] > ONE_Q30_S) begin
      zc_nxt = ONE_Q30;
    end else begin
      zc_nxt = vz_r[ITERS][30:0];
    end
    qv_full = 64'(rk_r) * 64'(zc_r);
    fsum    = 76'(acc_r) + (76'(pp11b_r) << 32) + (76'd1 << 37);
  end

  always_ff @(posedge clk) begin
    zc_r    <= zc_nxt;
    rk_r    <= 33'(radius_r) * 33'(MM_PER_M);
    qv_r    <= qv_full[62:0];
    pp00_r  <= 64'(qv_r[31:0]) * 64'(PI_LO);
    pp01_r  <= 42'(qv_r[31:0]) * 42'(PI_HI);
    pp10_r  <= 63'(qv_r[62:32]) * 63'(PI_LO);
    pp11_r  <= 41'(qv_r[62:32]) * 41'(PI_HI);
    acc_r   <= 66'(pp00_r[63:32]) + 66'(pp01_r) + 66'(pp10_r);
    pp11b_r <= pp11_r;
    dist_r  <= fsum[72:38];
  end

  assign out_valid       = vld_r[LAT-1];
  assign out_distance_mm = dist_r;

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> ##(LAT) out_valid)
    else $error("result strobe missing after fixed latency");

  a_hav: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[HAV_STG-1] |-> (hav_r <= ONE_Q60) && (hav_r + omh_r == ONE_Q60))
    else $error("hav out of range");

  a_root: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[SQ_END-1] |-> (sq_root_r[SQ_STG][0] <= 62'(ONE_Q30)) &&
                        (sq_root_r[SQ_STG][1] <= 62'(ONE_Q30)))
    else $error("square root exceeds one");

  a_zclamp: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[CLAMP_STG-1] |-> zc_r <= ONE_Q30)
    else $error("central angle clamp failed");

endmodule

FILE: dv/tb_haversine_distance.sv
module tb_haversine_distance;
  import hav_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam longint ARCTAN [30] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
    64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
    64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
    64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
    64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051, 64'h00000029,
    64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000003, 64'h00000001};

  class distance_scoreboard;
    logic [34:0]  pending_mm[$];
    logic [22:0]  radius_m;
    int           errors;
    int           checked;

    function new();
      radius_m = 23'd6371000;
      errors   = 0;
      checked  = 0;
    endfunction

    function logic [31:0] to_turn(longint d, int sh);
      longint r;
      longint unsigned u;
      r = d % 64'sd3600000000;
      if (r < 0) r += 64'sd3600000000;
      u = r;
      u = ((u << sh) + 64'd1800000000) / 64'd3600000000;
      return u[31:0];
    endfunction

    function void rotate(logic [31:0] t, output longint s, output longint c);
      longint x, y, z, dx, dy;
      x = 652032874;
      y = 0;
      z = {34'd0, t[29:0]};
      for (int i = 0; i < 30; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x -= dx; y += dy; z -= ARCTAN[i];
        end else begin
          x += dx; y -= dy; z += ARCTAN[i];
        end
      end
      case (t[31:30])
        QUAD_0: begin c = x;  s = y;  end
        QUAD_1: begin c = -y; s = x;  end
        QUAD_2: begin c = -x; s = -y; end
        default: begin c = y; s = -x; end
      endcase
    endfunction

    function longint unsigned int_sqrt(longint unsigned n);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
        if (n >= res + b) begin
          n -= res + b;
          res = (res >> 1) + b;
        end else begin
          res >>= 1;
        end
        b >>= 2;
      end
      return res;
    endfunction

    function logic [34:0] distance(longint la, longint oa, longint lb, longint ob);
      longint s1, c1, s2, c2, sa, ca, sb, cb, cc, t, hv, x, y, z, dx, dy;
      longint unsigned q;
      logic [127:0] p;
      rotate(to_turn(lb - la, 31), s1, c1);
      rotate(to_turn(ob - oa, 31), s2, c2);
      rotate(to_turn(la, 32), sa, ca);
      rotate(to_turn(lb, 32), sb, cb);
      cc = (ca * cb + 64'sd536870912) >>> 30;
      t  = (cc * s2 + 64'sd536870912) >>> 30;
      hv = s1 * s1 + t * s2;
      if (hv < 0) hv = 0;
      if (hv > 64'sh1000000000000000) hv = 64'sh1000000000000000;
      x = int_sqrt(64'h1000000000000000 - hv);
      y = int_sqrt(hv);
      z = 0;
      for (int i = 0; i < 30; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (y >= 0) begin
          x += dx; y -= dy; z += ARCTAN[i];
        end else begin
          x -= dx; y += dy; z -= ARCTAN[i];
        end
      end
      if (z < 0) z = 0;
      if (z > 64'sd1073741824) z = 64'sd1073741824;
      q = 64'(radius_m) * 64'd1000 * 64'(z);
      p = 128'(q) * 128'(64'd3454217652358) + (128'd1 << 69);
      return p[104:70];
    endfunction

    function void note_word(logic signed [30:0] la, logic signed [31:0] oa,
                            logic signed [30:0] lb, logic signed [31:0] ob);
      pending_mm.push_back(distance(la, oa, lb, ob));
    endfunction

    function void check_result(logic [34:0] got);
      logic [34:0] want;
      if (pending_mm.size() == 0) begin
        $error("distance_mm: unexpected result %0d", got);
        errors++;
        return;
      end
      want = pending_mm.pop_front();
      checked++;
      if (got !== want) begin
        $error("distance_mm expected %0d actual %0d", want, got);
        errors++;
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic signed [30:0] in_lat_a = '0;
  logic signed [31:0] in_lon_a = '0;
  logic signed [30:0] in_lat_b = '0;
  logic signed [31:0] in_lon_b = '0;
  logic               out_valid;
  logic [34:0]        out_distance_mm;
  logic               cfg_we = 1'b0;
  logic [22:0]        cfg_wdata = '0;

  distance_scoreboard sb = new();
  bit  idle_on;
  int  sent;

  haversine_distance u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_lat_a(in_lat_a), .in_lon_a(in_lon_a), .in_lat_b(in_lat_b), .in_lon_b(in_lon_b),
    .out_valid(out_valid), .out_distance_mm(out_distance_mm),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) sb.note_word(in_lat_a, in_lon_a, in_lat_b, in_lon_b);
      if (out_valid) sb.check_result(out_distance_mm);
      if (cfg_we) sb.radius_m = cfg_wdata;
    end
  end

  task automatic send_word(logic signed [30:0] la, logic signed [31:0] oa,
                           logic signed [30:0] lb, logic signed [31:0] ob);
    while (idle_on && $urandom_range(99) < 35) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start    <= 1'b1;
    in_lat_a <= la;
    in_lon_a <= oa;
    in_lat_b <= lb;
    in_lon_b <= ob;
    @(posedge clk);
    while (busy) @(posedge clk);
    sent++;
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending_mm.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_radius(logic [22:0] r);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= r;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic signed [31:0] rand_coord(int unsigned span);
    return $signed($urandom_range(2 * span)) - $signed(span);
  endfunction

  task automatic send_random(int n);
    int kind;
    logic signed [31:0] la, oa, lb, ob;
    for (int i = 0; i < n; i++) begin
      idle_on = !(i >= n / 3 && i < n / 2);
      kind = $urandom_range(9);
      la = rand_coord(900000000);
      oa = rand_coord(1800000000);
      lb = rand_coord(900000000);
      ob = rand_coord(1800000000);
      case (kind)
        0: begin
          la = $urandom; oa = $urandom; lb = $urandom; ob = $urandom;
        end
        1: begin
          lb = la + rand_coord(1000);
          ob = oa + rand_coord(1000);
        end
        2: begin
          lb = -la;
          ob = oa + 32'sd1800000000 + rand_coord(50);
        end
        default: ;
      endcase
      send_word(la[30:0], oa, lb[30:0], ob);
    end
  endtask

  initial begin
    idle_on = 1'b1;
    sent = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_word(0, 0, 0, 0);
    send_word(31'sd900000000, 0, -31'sd900000000, 0);
    send_word(31'sd900000000, 32'sd1800000000, 31'sd900000000, -32'sd1800000000);
    send_word(0, 0, 0, 32'sd1800000000);
    send_word(0, -32'sd1800000000, 0, 32'sd1800000000);
    send_word(-31'sd900000000, 0, 31'sd900000000, 32'sd1800000000);
    send_word(31'sd123456789, 32'sd987654321, 31'sd123456789, 32'sd987654321);
    send_word(0, 0, 1, 0);
    send_word(0, 0, 0, 1);
    send_word(31'sd450000000, 0, -31'sd450000000, 32'sd1800000000);
    send_word(31'sd899999999, 32'sd10, -31'sd899999999, -32'sd1799999990);
    send_word({1'b1, 30'd0}, {1'b1, 31'd0}, {1'b0, {30{1'b1}}}, {1'b0, {31{1'b1}}});
    send_word({1'b0, {30{1'b1}}}, {1'b0, {31{1'b1}}}, {1'b1, 30'd0}, {1'b1, 31'd0});
    send_word(31'sd1000000000, 0, -31'sd1000000000, 32'sd5);
    send_word({31{1'b1}}, {32{1'b1}}, 0, 0);
    send_word(31'sd10, 32'sd20, -31'sd10, -32'sd20);

    write_radius(23'd1);
    send_word(31'sd900000000, 0, -31'sd900000000, 0);
    send_random(230);
    write_radius(23'd8388607);
    send_word(31'sd900000000, 0, -31'sd900000000, 0);
    send_word(0, 0, 0, 32'sd1800000000);
    send_random(230);
    write_radius(23'd0);
    send_random(60);
    write_radius(23'd6371000);
    send_random(340);
    write_radius(23'd1 + 23'($urandom_range(8388605)));
    send_random(290);

    drain();
    repeat (120) @(posedge clk);
    $display("Sent %0d coordinate words, checked %0d distances over five radius settings",
             sent, sb.checked);
    $display("including zero, minimum, maximum and reset radius");
    if (sb.errors == 0 && sb.pending_mm.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #(12 * 200000);
    $display("FAIL");
    $finish;
  end

endmodule
